@@ rtl/dbem_pkg.sv @@
`timescale 1ns / 1ps
package dbem_pkg;
    localparam int FRAC_BITS   = 16;
    localparam int SCORE_DIV   = 11;
    localparam int BLOCK_COEFS = 64;

    typedef enum logic [1:0] {
        CFG_HIPASS = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_index_t;

    // per-coefficient job handed from front to back
    typedef struct packed {
        logic        counted;
        logic        block_end;
        logic [11:0] bin;
        logic [5:0]  hipass;
    } job_t;

    // round(65536*log2(c)), c = 0..64
    function automatic logic [18:0] log2_q16(input logic [6:0] c);
        logic [18:0] r;
        begin
            case (c)
                7'd2: r = 19'd65536;   7'd3: r = 19'd103872; 7'd4: r = 19'd131072;
                7'd5: r = 19'd152170;  7'd6: r = 19'd169408; 7'd7: r = 19'd183983;
                7'd8: r = 19'd196608;  7'd9: r = 19'd207744; 7'd10: r = 19'd217706;
                7'd11: r = 19'd226717; 7'd12: r = 19'd234944; 7'd13: r = 19'd242512;
                7'd14: r = 19'd249519; 7'd15: r = 19'd256042; 7'd16: r = 19'd262144;
                7'd17: r = 19'd267876; 7'd18: r = 19'd273280; 7'd19: r = 19'd278392;
                7'd20: r = 19'd283242; 7'd21: r = 19'd287855; 7'd22: r = 19'd292253;
                7'd23: r = 19'd296456; 7'd24: r = 19'd300480; 7'd25: r = 19'd304340;
                7'd26: r = 19'd308048; 7'd27: r = 19'd311616; 7'd28: r = 19'd315055;
                7'd29: r = 19'd318373; 7'd30: r = 19'd321578; 7'd31: r = 19'd324678;
                7'd32: r = 19'd327680; 7'd33: r = 19'd330589; 7'd34: r = 19'd333412;
                7'd35: r = 19'd336153; 7'd36: r = 19'd338816; 7'd37: r = 19'd341407;
                7'd38: r = 19'd343928; 7'd39: r = 19'd346384; 7'd40: r = 19'd348778;
                7'd41: r = 19'd351113; 7'd42: r = 19'd353391; 7'd43: r = 19'd355616;
                7'd44: r = 19'd357789; 7'd45: r = 19'd359914; 7'd46: r = 19'd361992;
                7'd47: r = 19'd364026; 7'd48: r = 19'd366016; 7'd49: r = 19'd367966;
                7'd50: r = 19'd369876; 7'd51: r = 19'd371748; 7'd52: r = 19'd373584;
                7'd53: r = 19'd375385; 7'd54: r = 19'd377152; 7'd55: r = 19'd378887;
                7'd56: r = 19'd380591; 7'd57: r = 19'd382264; 7'd58: r = 19'd383909;
                7'd59: r = 19'd385525; 7'd60: r = 19'd387114; 7'd61: r = 19'd388677;
                7'd62: r = 19'd390214; 7'd63: r = 19'd391727; 7'd64: r = 19'd393216;
                default: r = 19'd0;
            endcase
            return r;
        end
    endfunction
endpackage

@@ rtl/dbem_if.sv @@
`timescale 1ns / 1ps
interface dbem_in_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] coef;
    logic [15:0]        quant;
    modport source (output valid, coef, quant, input ready);
    modport sink (input valid, coef, quant, output ready);
endinterface

interface dbem_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] entropy;
    logic [7:0] max_entropy;
    logic [7:0] average;
    logic [7:0] x_centroid;
    logic [7:0] y_centroid;
    logic       last;
    modport source (output valid, kind, entropy, max_entropy, average, x_centroid,
        y_centroid, last, input ready);
    modport sink (input valid, kind, entropy, max_entropy, average, x_centroid,
        y_centroid, last, output ready);
endinterface

@@ rtl/dct_block_entropy_map_unit.sv @@
`timescale 1ns / 1ps
// dct block entropy map
// in channel: one word per coefficient (coef, quant), 64 per 8x8 block,
//   natural order, blocks in raster order
// out channel: a block word (kind 0) after each 64th coefficient; after the
//   last block of the image a second, summary word (kind 1, last 1)
// config: write hipass (0), width_blocks (1), height_blocks (2) while idle
// front end queues classified coefficients in a two-word fifo; the back end
//   does a histogram read-modify-write per coefficient, reading in S_IDLE and writing in S_UPD before it takes the next
// block end: a score division, then a histogram clear
// image end: a column walk, three divides and a column clear, then the
//   histogram clear
// reset: column clear then histogram clear; the front fifo takes up to
//   two words meanwhile
// receiver stall: result word holds in the output register, back end waits;
//   the front keeps taking words until its fifo fills
module dct_block_entropy_map_unit
    import dbem_pkg::*;
#(
    parameter int BIN_COUNT   = 2048,
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    dbem_in_if.sink     in_ch,
    dbem_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [5:0] hipass_reg;
    logic [8:0] width_reg, height_reg;
    logic       job_valid, job_ready;
    job_t       job;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hipass_reg <= '0;
            width_reg  <= 9'd1;
            height_reg <= 9'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIPASS: hipass_reg <= cfg_data[5:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    dbem_front #(.BIN_W(BIN_W)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .coef(in_ch.coef), .quant(in_ch.quant), .hipass(hipass_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    dbem_back #(.BIN_W(BIN_W), .COL_W(COL_W), .MAX_COLS(MAX_COLUMNS),
        .MAX_ROWS(MAX_ROWS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .width_blocks(width_reg), .height_blocks(height_reg),
        .res(out_ch)
    );
endmodule

@@ rtl/dbem_front.sv @@
`timescale 1ns / 1ps
module dbem_front
    import dbem_pkg::*;
#(
    parameter int BIN_W = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [11:0] coef,
    input  logic [15:0] quant,
    input  logic [5:0]  hipass,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);
    localparam int     HALF = 1 << (BIN_W - 1);
    localparam logic signed [28:0] PMAX = 29'(HALF - 1);
    localparam logic signed [28:0] PMIN = -29'(HALF);

    logic [5:0]  pos_reg;
    logic [1:0]  cnt_reg;
    job_t        q_reg [2];
    logic        wp_reg, rp_reg;
    logic signed [28:0] prod;
    logic signed [28:0] sat;
    job_t        nj;
    logic        push, pop;

    // two-entry queue toward the histogram back end
    assign in_ready  = cnt_reg != 2'd2;
    assign job_valid = cnt_reg != 2'd0;
    assign job       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        prod = coef * $signed({1'b0, quant});
        if (prod > PMAX)
            sat = PMAX;
        else if (prod < PMIN)
            sat = PMIN;
        else
            sat = prod;
        nj.counted   = pos_reg >= hipass;
        nj.block_end = pos_reg == 6'd63;
        nj.bin       = 12'(sat + 29'(HALF));
        nj.hipass    = hipass;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                pos_reg <= pos_reg + 6'd1;
                wp_reg  <= ~wp_reg;
            end
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= nj;
    end
endmodule

@@ rtl/dbem_back.sv @@
`timescale 1ns / 1ps
module dbem_back
    import dbem_pkg::*;
#(
    parameter int BIN_W    = 11,
    parameter int COL_W    = 8,
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    input  logic [8:0] width_blocks,
    input  logic [8:0] height_blocks,
    dbem_out_if.source res
);
    localparam int BINS = 1 << BIN_W;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_RD, S_UPD, S_DIV, S_ACC, S_SUM, S_SDIV, S_CDIV,
        S_OUT1, S_OUT2, S_IMG_CLR
    } state_t;

    state_t      st_reg;
    logic [6:0]  bins_mem [BINS];
    logic [15:0] colm [MAX_COLS];
    logic [BIN_W-1:0] bclr_reg;
    logic [BIN_W:0]   vclr_reg;
    logic [25:0] lsum_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [6:0]  rd_reg;
    logic        cnt_reg_q;
    logic [5:0]  hp_reg;
    logic [9:0]  col_reg, row_reg;
    logic [15:0] rsum_reg;
    logic [31:0] rwt_reg;
    logic [23:0] tot_reg;
    logic [7:0]  peak_reg;
    logic [7:0]  ent_reg;
    logic [40:0] xsum_reg;
    logic [10:0] sidx_reg;
    logic [15:0] crd_reg;
    logic        last_blk_reg;
    // shared restoring divider
    logic [40:0] dnum_reg;
    logic [40:0] drem_reg;
    logic [40:0] dden_reg;
    logic [40:0] dquo_reg;
    logic [5:0]  dstep_reg;
    logic [1:0]  dsel_reg;
    logic [7:0]  avg_reg, xc_reg;
    logic        o_valid_reg, o_kind_reg, o_last_reg;
    logic [7:0]  o_ent_reg, o_max_reg, o_avg_reg, o_xc_reg, o_yc_reg;
    logic [9:0]  w_eff, h_eff;
    logic [6:0]  n7;
    logic [25:0] delta;
    logic [6:0]  ll;
    logic [25:0] lfull;
    logic [41:0] rem_sh;

    function automatic logic [9:0] eff(input logic [8:0] v, input int lim);
        logic [9:0] r;
        begin
            if (v == 9'd0)
                r = 10'd1;
            else if (int'(v) > lim)
                r = 10'(lim);
            else
                r = {1'b0, v};
            return r;
        end
    endfunction

    assign w_eff = eff(width_blocks, MAX_COLS);
    assign h_eff = eff(height_blocks, MAX_ROWS);
    assign job_ready = st_reg == S_IDLE;
    assign n7    = (vclr_reg > {1'b0, bin_reg}) ? rd_reg : 7'd0;
    assign delta = 26'(({19'd0, n7} + 26'd1) * log2_q16(n7 + 7'd1))
                 - 26'({19'd0, n7} * log2_q16(n7));
    assign ll    = 7'd64 - {1'b0, hp_reg};
    assign lfull = 26'({19'd0, ll} * log2_q16(ll));
    assign rem_sh = {drem_reg, dnum_reg[40]};

    assign res.valid       = o_valid_reg;
    assign res.kind        = o_kind_reg;
    assign res.entropy     = o_ent_reg;
    assign res.max_entropy = o_max_reg;
    assign res.average     = o_avg_reg;
    assign res.x_centroid  = o_xc_reg;
    assign res.y_centroid  = o_yc_reg;
    assign res.last        = o_last_reg;

    always_ff @(posedge clk)
    begin
        rd_reg  <= bins_mem[job.bin[BIN_W-1:0]];
        if (st_reg == S_SUM)
            crd_reg <= colm[sidx_reg[COL_W-1:0]];
        else
            crd_reg <= colm[col_reg[COL_W-1:0]];
        if (st_reg == S_UPD && cnt_reg_q && n7 < 7'd64)
            bins_mem[bin_reg] <= n7 + 7'd1;
        if (st_reg == S_CLEAR)
            bins_mem[bclr_reg] <= 7'd0;
        if (st_reg == S_ACC)
            colm[col_reg[COL_W-1:0]] <= crd_reg + {8'd0, ent_reg};
        if (st_reg == S_IMG_CLR)
            colm[sidx_reg[COL_W-1:0]] <= 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IMG_CLR;
            vclr_reg <= '0;
            bclr_reg <= '0;
            lsum_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            rsum_reg <= '0;
            rwt_reg <= '0;
            tot_reg <= '0;
            peak_reg <= '0;
            sidx_reg <= '0;
            o_valid_reg <= 1'b0;
            o_kind_reg <= 1'b0;
            o_last_reg <= 1'b0;
            dstep_reg <= '0;
            dsel_reg <= '0;
        end
        else
        begin
            case (st_reg)
                S_IMG_CLR:
                begin
                    // column sums swept to zero, one per cycle
                    sidx_reg <= sidx_reg + 11'd1;
                    if (int'(sidx_reg) == MAX_COLS - 1)
                    begin
                        sidx_reg <= '0;
                        st_reg <= (vclr_reg == BINS[BIN_W:0]) ? S_IDLE : S_CLEAR;
                    end
                end
                S_CLEAR:
                begin
                    bclr_reg <= bclr_reg + 1'b1;
                    vclr_reg <= vclr_reg + 1'b1;
                    if (int'(bclr_reg) == BINS - 1)
                        st_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        bin_reg <= job.bin[BIN_W-1:0];
                        cnt_reg_q <= job.counted;
                        hp_reg <= job.hipass;
                        last_blk_reg <= job.block_end;
                        st_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    logic [25:0] ns;
                    ns = lsum_reg;
                    if (cnt_reg_q && n7 < 7'd64)
                        ns = lsum_reg + delta;
                    lsum_reg <= ns;
                    if (last_blk_reg)
                    begin
                        dnum_reg <= (lfull > ns) ? 41'({15'd0, lfull - ns} << 8) : 41'd0;
                        dden_reg <= 41'(({34'd0, ll} * 41'd11) << FRAC_BITS);
                        drem_reg <= '0;
                        dstep_reg <= '0;
                        dsel_reg <= 2'd0;
                        st_reg <= S_DIV;
                    end
                    else
                        st_reg <= S_IDLE;
                end
                S_DIV, S_SDIV, S_CDIV:
                begin
                    // one quotient bit per cycle
                    if (rem_sh >= {1'b0, dden_reg})
                    begin
                        drem_reg <= 41'(rem_sh - {1'b0, dden_reg});
                        dquo_reg <= {dquo_reg[39:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= rem_sh[40:0];
                        dquo_reg <= {dquo_reg[39:0], 1'b0};
                    end
                    dnum_reg <= {dnum_reg[39:0], 1'b0};
                    dstep_reg <= dstep_reg + 6'd1;
                    if (dstep_reg == 6'd40)
                    begin
                        dstep_reg <= '0;
                        if (st_reg == S_DIV)
                        begin
                            ent_reg <= 8'({dquo_reg[39:0], rem_sh >= {1'b0, dden_reg}});
                            st_reg <= S_ACC;
                        end
                        else if (dsel_reg == 2'd0)
                        begin
                            logic [40:0] qv;
                            qv = {dquo_reg[39:0], rem_sh >= {1'b0, dden_reg}};
                            avg_reg <= (qv > 41'd255) ? 8'd255 : qv[7:0];
                            dnum_reg <= xsum_reg;
                            dden_reg <= {17'd0, tot_reg};
                            drem_reg <= '0;
                            dsel_reg <= 2'd1;
                        end
                        else if (dsel_reg == 2'd1)
                        begin
                            xc_reg <= 8'({dquo_reg[39:0], rem_sh >= {1'b0, dden_reg}});
                            dnum_reg <= {9'd0, rwt_reg};
                            drem_reg <= '0;
                            dsel_reg <= 2'd2;
                        end
                        else
                        begin
                            o_valid_reg <= 1'b1;
                            o_kind_reg <= 1'b1;
                            o_ent_reg <= '0;
                            o_max_reg <= peak_reg;
                            o_avg_reg <= avg_reg;
                            o_xc_reg <= (tot_reg == 0) ? 8'd0 : xc_reg;
                            o_yc_reg <= (tot_reg == 0) ? 8'd0 :
                                8'({dquo_reg[39:0], rem_sh >= {1'b0, dden_reg}});
                            o_last_reg <= 1'b1;
                            st_reg <= S_OUT2;
                        end
                    end
                end
                S_ACC:
                begin
                    // ent in hand, column sum read; update image totals, load the block word
                    logic [15:0] rs;
                    rs = rsum_reg + {8'd0, ent_reg};
                    if (ent_reg > peak_reg)
                        peak_reg <= ent_reg;
                    tot_reg <= tot_reg + {16'd0, ent_reg};
                    lsum_reg <= '0;
                    bclr_reg <= '0;
                    vclr_reg <= '0;
                    o_valid_reg <= 1'b1;
                    o_kind_reg <= 1'b0;
                    o_ent_reg <= ent_reg;
                    o_max_reg <= '0;
                    o_avg_reg <= '0;
                    o_xc_reg <= '0;
                    o_yc_reg <= '0;
                    if (col_reg + 10'd1 < w_eff)
                    begin
                        col_reg <= col_reg + 10'd1;
                        rsum_reg <= rs;
                        o_last_reg <= 1'b1;
                    end
                    else
                    begin
                        rwt_reg <= rwt_reg + 32'({16'd0, row_reg} * rs);
                        rsum_reg <= '0;
                        col_reg <= '0;
                        if (row_reg + 10'd1 < h_eff)
                        begin
                            row_reg <= row_reg + 10'd1;
                            o_last_reg <= 1'b1;
                        end
                        else
                        begin
                            o_last_reg <= 1'b0;
                            xsum_reg <= '0;
                            sidx_reg <= '0;
                        end
                    end
                    st_reg <= S_OUT1;
                end
                S_OUT1:
                begin
                    if (res.ready)
                    begin
                        o_valid_reg <= 1'b0;
                        if (o_last_reg)
                            st_reg <= S_CLEAR;
                        else
                            st_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    // weighted column sum; each column is read in the cycle before it is added
                    if (sidx_reg != 11'd0)
                        xsum_reg <= xsum_reg + 41'({16'd0, sidx_reg - 11'd1} * crd_reg);
                    sidx_reg <= sidx_reg + 11'd1;
                    if (int'(sidx_reg) == MAX_COLS)
                    begin
                        dnum_reg <= {17'd0, tot_reg};
                        dden_reg <= 41'({10'd0, w_eff} * h_eff);
                        drem_reg <= '0;
                        dsel_reg <= 2'd0;
                        dstep_reg <= '0;
                        st_reg <= S_SDIV;
                    end
                end
                S_OUT2:
                begin
                    if (res.ready)
                    begin
                        o_valid_reg <= 1'b0;
                        col_reg <= '0;
                        row_reg <= '0;
                        rsum_reg <= '0;
                        rwt_reg <= '0;
                        tot_reg <= '0;
                        peak_reg <= '0;
                        sidx_reg <= '0;
                        st_reg <= S_IMG_CLR;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_single_out: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> (st_reg == S_OUT1 || st_reg == S_OUT2)) else $error("out");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_CLEAR) |-> !job_ready) else $error("clear");
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_kind_reg) |-> o_last_reg) else $error("sum");
endmodule

@@ bench/dbem_checker.sv @@
`timescale 1ns / 1ps
module dbem_checker
    import dbem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dbem_in_if         in_ch,
    dbem_out_if        out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    output int         fail_count,
    output int         pending
);
    localparam int HIST_BINS = 2048;
    localparam int COLUMNS   = 256;
    localparam int ROWS      = 256;

    localparam int unsigned LOG2_FIX [0:64] = '{
        0, 0, 65536, 103872, 131072, 152170, 169408, 183983,
        196608, 207744, 217706, 226717, 234944, 242512, 249519, 256042,
        262144, 267876, 273280, 278392, 283242, 287855, 292253, 296456,
        300480, 304340, 308048, 311616, 315055, 318373, 321578, 324678,
        327680, 330589, 333412, 336153, 338816, 341407, 343928, 346384,
        348778, 351113, 353391, 355616, 357789, 359914, 361992, 364026,
        366016, 367966, 369876, 371748, 373584, 375385, 377152, 378887,
        380591, 382264, 383909, 385525, 387114, 388677, 390214, 391727,
        393216
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] entropy;
        logic [7:0] max_entropy;
        logic [7:0] average;
        logic [7:0] x_centroid;
        logic [7:0] y_centroid;
        logic       last;
    } score_word_t;

    score_word_t       score_queue[$];
    logic [6:0]        bin_counts [HIST_BINS];
    int unsigned       log_sum;
    int unsigned       coef_pos;
    int unsigned       blk_col;
    int unsigned       blk_row;
    int unsigned       col_sums [COLUMNS];
    int unsigned       row_acc;
    longint unsigned   row_weighted;
    longint unsigned   grand_total;
    int unsigned       peak;
    logic [5:0]        hipass;
    logic [8:0]        width_cfg;
    logic [8:0]        height_cfg;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    task automatic clear_image();
        blk_col = 0;
        blk_row = 0;
        foreach (col_sums[i])
            col_sums[i] = 0;
        row_acc = 0;
        row_weighted = 0;
        grand_total = 0;
        peak = 0;
    endtask

    task automatic report(string what, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic absorb_coef(logic signed [11:0] c, logic [15:0] q);
        longint          prod;
        longint          num;
        int unsigned     idx;
        int unsigned     n;
        int unsigned     l;
        int unsigned     w;
        int unsigned     h;
        longint unsigned ent;
        longint unsigned xsum;
        longint unsigned avg;
        score_word_t     word;
        prod = longint'(c) * longint'(q);
        if (prod < -(HIST_BINS / 2))
            prod = -(HIST_BINS / 2);
        if (prod > HIST_BINS / 2 - 1)
            prod = HIST_BINS / 2 - 1;
        if (coef_pos >= hipass)
        begin
            idx = int'(prod) + HIST_BINS / 2;
            n = bin_counts[idx];
            // a bin saturates at a full block
            if (n < BLOCK_COEFS)
            begin
                log_sum += (n + 1) * LOG2_FIX[n + 1] - n * LOG2_FIX[n];
                bin_counts[idx] = 7'(n + 1);
            end
        end
        coef_pos++;
        if (coef_pos < BLOCK_COEFS)
            return;
        coef_pos = 0;

        // block end: l uses hipass as it stands now
        l = BLOCK_COEFS - hipass;
        num = longint'(l) * longint'(LOG2_FIX[l]) - longint'(log_sum);
        if (num < 0)
            num = 0;
        ent = (longint'(num) * 256) / ((longint'(SCORE_DIV) * l) << FRAC_BITS);
        foreach (bin_counts[i])
            bin_counts[i] = '0;
        log_sum = 0;

        w = clamp_dim(width_cfg, COLUMNS);
        h = clamp_dim(height_cfg, ROWS);
        if (ent > peak)
            peak = int'(ent);
        grand_total += ent;
        col_sums[blk_col] += int'(ent);
        row_acc += int'(ent);

        word = '0;
        word.entropy = 8'(ent);
        word.last = 1'b1;
        if (blk_col + 1 < w)
        begin
            blk_col++;
            score_queue.push_back(word);
            return;
        end
        row_weighted += longint'(blk_row) * row_acc;
        row_acc = 0;
        blk_col = 0;
        if (blk_row + 1 < h)
        begin
            blk_row++;
            score_queue.push_back(word);
            return;
        end

        // image end: block word then the summary word
        word.last = 1'b0;
        score_queue.push_back(word);
        xsum = 0;
        foreach (col_sums[i])
            xsum += longint'(i) * col_sums[i];
        avg = grand_total / (longint'(w) * h);
        if (avg > 255)
            avg = 255;
        word = '0;
        word.kind = 1'b1;
        word.max_entropy = 8'(peak);
        word.average = 8'(avg);
        word.x_centroid = grand_total != 0 ? 8'(xsum / grand_total) : 8'd0;
        word.y_centroid = grand_total != 0 ? 8'(row_weighted / grand_total) : 8'd0;
        word.last = 1'b1;
        score_queue.push_back(word);
        clear_image();
    endtask

    task automatic check_word();
        score_word_t want;
        if (score_queue.size() == 0)
        begin
            report("unexpected word", 1, 0);
            return;
        end
        want = score_queue.pop_front();
        if (out_ch.kind !== want.kind)
            report("kind", out_ch.kind, want.kind);
        if (out_ch.entropy !== want.entropy)
            report("entropy", out_ch.entropy, want.entropy);
        if (out_ch.max_entropy !== want.max_entropy)
            report("max_entropy", out_ch.max_entropy, want.max_entropy);
        if (out_ch.average !== want.average)
            report("average", out_ch.average, want.average);
        if (out_ch.x_centroid !== want.x_centroid)
            report("x_centroid", out_ch.x_centroid, want.x_centroid);
        if (out_ch.y_centroid !== want.y_centroid)
            report("y_centroid", out_ch.y_centroid, want.y_centroid);
        if (out_ch.last !== want.last)
            report("last", out_ch.last, want.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_queue.delete();
            foreach (bin_counts[i])
                bin_counts[i] = '0;
            log_sum = 0;
            coef_pos = 0;
            clear_image();
            hipass = '0;
            width_cfg = 9'd1;
            height_cfg = 9'd1;
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HIPASS: hipass = cfg_data[5:0];
                    CFG_WIDTH:  width_cfg = cfg_data;
                    CFG_HEIGHT: height_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                absorb_coef(in_ch.coef, in_ch.quant);
            if (out_ch.valid && out_ch.ready)
                check_word();
            pending <= score_queue.size();
        end
    end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import dbem_pkg::*;

    // long enough for block clears and the image-end walk
    localparam int SETTLE_CYCLES = 3000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;
    int         fail_count;
    int         pending;
    int         words_sent;
    bit         no_idle;
    int         ready_hold;

    dbem_in_if  in_ch ();
    dbem_out_if out_ch ();

    dct_block_entropy_map_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dbem_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // receiver stalls, changed at the falling edge
    always @(negedge clk)
    begin
        if (ready_hold > 0)
            ready_hold--;
        else if (no_idle)
            out_ch.ready = 1'b1;
        else
        begin
            out_ch.ready = $urandom_range(3) != 0;
            ready_hold = out_ch.ready ? $urandom_range(6) : pick_gap();
        end
    end

    // one coefficient word; valid stays high into the next word when no gap
    task automatic send_coef(logic signed [11:0] c, logic [15:0] q);
        int g;
        g = pick_gap();
        @(negedge clk);
        if (g > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.coef = c;
        in_ch.quant = q;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // drop valid, wait for all words out, then let clears finish
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = 9'(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // n coefficients with a random texture: narrow range, full range, or flat
    task automatic send_coefs(int n);
        int style;
        int span;
        style = $urandom_range(9);
        span = $urandom_range(40, 1);
        no_idle = $urandom_range(4) == 0;
        for (int i = 0; i < n; i++)
        begin
            if (style < 5)
                send_coef(12'($signed($urandom_range(2 * span)) - span),
                          16'($urandom_range(4)));
            else if (style < 8)
                send_coef(12'($urandom), 16'($urandom));
            else
                send_coef(12'sd3, 16'd5);
        end
    endtask

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int w;
        int h;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HIPASS;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.coef = '0;
        in_ch.quant = '0;
        out_ch.ready = 1'b0;
        ready_hold = 0;
        no_idle = 1'b0;
        words_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: 1x1 image, full histogram; field extremes and zero quant
        send_coef(-12'sd2048, 16'd1);
        send_coef(12'sd2047, 16'd1);
        send_coef(-12'sd2048, 16'd65535);
        send_coef(12'sd2047, 16'd65535);
        send_coef(12'sd0, 16'd65535);
        send_coef(12'sd5, 16'd0);
        send_coef(-12'sd1, 16'd1);
        send_coef(12'sd1, 16'd1023);
        send_coef(-12'sd1, 16'd1024);
        send_coef(-12'sd1, 16'd1025);
        send_coef(12'sd1, 16'd1024);
        send_coefs(53);
        // all coefficients distinct: top score
        for (int i = 0; i < 64; i++)
            send_coef(12'(i - 32), 16'd1);
        // all in one bin: score zero
        send_coefs(0);
        for (int i = 0; i < 64; i++)
            send_coef(12'sd0, 16'd7);
        wait_idle();

        // single counted position, 3x2 image
        write_reg(CFG_HIPASS, 63);
        write_reg(CFG_WIDTH, 3);
        write_reg(CFG_HEIGHT, 2);
        repeat (6) send_coefs(64);
        wait_idle();

        // hipass raised mid-block: large log sum against a short block
        write_reg(CFG_HIPASS, 0);
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, 1);
        for (int i = 0; i < 40; i++)
            send_coef(12'sd2, 16'd2);
        wait_idle();
        write_reg(CFG_HIPASS, 60);
        send_coefs(24);
        wait_idle();

        // zero width acts as one, oversize height cut short mid-image
        write_reg(CFG_WIDTH, 0);
        write_reg(CFG_HEIGHT, 300);
        repeat (2) send_coefs(64);
        wait_idle();
        write_reg(CFG_HEIGHT, 1);
        send_coefs(64);
        wait_idle();

        // widest rows (511 clamps to 256), rewritten to 256 mid-row, then narrowed; tallest image narrowed too
        write_reg(CFG_HIPASS, 10);
        write_reg(CFG_WIDTH, 511);
        write_reg(CFG_HEIGHT, 256);
        repeat (2) send_coefs(64);
        wait_idle();
        write_reg(CFG_WIDTH, 256);
        send_coefs(64);
        wait_idle();
        write_reg(CFG_WIDTH, 2);
        write_reg(CFG_HEIGHT, 2);
        repeat (3) send_coefs(64);
        wait_idle();

        // random images with small dimensions
        while (words_sent < 1250)
        begin
            w = $urandom_range(4, 1);
            h = $urandom_range(3, 1);
            write_reg(CFG_HIPASS, $urandom_range(3) == 0 ? $urandom_range(63) : 0);
            write_reg(CFG_WIDTH, w);
            write_reg(CFG_HEIGHT, h);
            repeat (w * h) send_coefs(64);
            wait_idle();
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
